// ===== src/lru_pkg.sv =====
// ---------------------------------------------------------------------------
// lru_pkg: shared types and constants
// Entry count, index widths, sequencer states and the store access bundle.
// ---------------------------------------------------------------------------
package lru_pkg;
	localparam int CACHE_ENTRIES = 256;
	localparam int IDX_W = $clog2(CACHE_ENTRIES);
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
	localparam int TAG_W = 32;
	localparam int TOT_W = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE,
		ST_FINISH
	} lru_state_t;

	typedef struct packed {
		logic [IDX_W-1:0] rd_addr;
		logic             tag_we;
		logic             rank_we;
		logic [IDX_W-1:0] wr_addr;
		logic [TAG_W-1:0] tag_wd;
		logic [IDX_W-1:0] rank_wd;
	} lru_mem_req_t;
endpackage

// ===== src/lru_if.sv =====
// ---------------------------------------------------------------------------
// lru_if: stream channels
// Request channel carries a block number, response channel the result beat.
// ---------------------------------------------------------------------------
interface lru_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] block_number;
	modport source(output valid, output block_number, input ready);
	modport sink(input valid, input block_number, output ready);
endinterface

interface lru_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic        evicted;
	logic [31:0] hit_count;
	logic [31:0] reference_count;
	modport source(output valid, output hit, output evicted, output hit_count,
		output reference_count, input ready);
	modport sink(input valid, input hit, input evicted, input hit_count,
		input reference_count, output ready);
endinterface

// ===== src/lru_store.sv =====
// ---------------------------------------------------------------------------
// lru_store: tag and recency memories
// One read port shared by both arrays, one write port each, registered read.
// ---------------------------------------------------------------------------
module lru_store (
	input  logic                        clk,
	input  lru_pkg::lru_mem_req_t       req,
	output logic [lru_pkg::TAG_W-1:0]   tag_rd,
	output logic [lru_pkg::IDX_W-1:0]   rank_rd
);
	import lru_pkg::*;

	logic [TAG_W-1:0] tag_mem [CACHE_ENTRIES];
	logic [IDX_W-1:0] rank_mem [CACHE_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.tag_we) begin
			tag_mem[req.wr_addr] <= req.tag_wd;
		end
		tag_rd <= tag_mem[req.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (req.rank_we) begin
			rank_mem[req.wr_addr] <= req.rank_wd;
		end
		rank_rd <= rank_mem[req.rd_addr];
	end
endmodule

// ===== src/lru_cache_hit_tracker_unit.sv =====
// ---------------------------------------------------------------------------
// lru_cache_hit_tracker_unit: fully associative LRU cache tracker
// Looks up block numbers and reports hit, eviction and running counts.
// ---------------------------------------------------------------------------
// One reference at a time: a search pass reads every filled entry of the tag
// and rank memories (one entry a cycle through the shared read port), then an
// update pass rewrites each rank, then the finish state writes the new tag on
// a miss, waiting while the output register still holds an unread result. The
// result is held in an output register; the next reference is taken while it
// waits. No clearing pass after reset: the fill count bounds all reads.
module lru_cache_hit_tracker_unit (
	input logic      clk,
	input logic      arst_n,
	lru_req_if.sink  req,
	lru_rsp_if.source rsp
);
	import lru_pkg::*;

	lru_state_t       state_q, state_d;
	logic [CNT_W-1:0] k_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [TAG_W-1:0] blk_q;
	logic             found_q;
	logic [IDX_W-1:0] slot_q, hit_rank_q, vic_q;
	logic [CNT_W-1:0] fill_q;
	logic [TOT_W-1:0] hits_q, refs_q;
	logic             out_vld_q, out_hit_q, out_evi_q;
	logic [TOT_W-1:0] out_hits_q, out_refs_q;

	lru_mem_req_t     mreq;
	logic [TAG_W-1:0] tag_rd;
	logic [IDX_W-1:0] rank_rd;

	logic             accept, walking, walk_issue, walk_done, full, out_free, advance;
	logic [IDX_W-1:0] tgt_idx;

	lru_store u_store (
		.clk    (clk),
		.req    (mreq),
		.tag_rd (tag_rd),
		.rank_rd(rank_rd)
	);

	assign full       = (fill_q == CNT_W'(CACHE_ENTRIES));
	assign walking    = (state_q == ST_SEARCH) || (state_q == ST_UPDATE);
	assign walk_issue = walking && (k_q < fill_q);
	assign walk_done  = (k_q == fill_q) && !rd_vld_s1;
	assign out_free   = !out_vld_q || rsp.ready;
	assign accept     = req.valid && req.ready;
	assign advance    = (state_q == ST_FINISH) && out_free;
	assign tgt_idx    = found_q ? slot_q : (full ? vic_q : fill_q[IDX_W-1:0]);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (req.valid) state_d = ST_SEARCH;
			ST_SEARCH: if (walk_done) state_d = ST_UPDATE;
			ST_UPDATE: if (walk_done) state_d = ST_FINISH;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready     = (state_q == ST_IDLE);
		mreq.rd_addr  = k_q[IDX_W-1:0];
		mreq.tag_we   = 1'b0;
		mreq.rank_we  = 1'b0;
		mreq.wr_addr  = rd_idx_s1;
		mreq.tag_wd   = blk_q;
		mreq.rank_wd  = rank_rd;
		unique case (state_q)
			ST_UPDATE: begin
				mreq.rank_we = rd_vld_s1;
				if (rd_idx_s1 == tgt_idx) begin
					mreq.rank_wd = '0;
				end else if (!found_q || (rank_rd < hit_rank_q)) begin
					mreq.rank_wd = rank_rd + IDX_W'(1);
				end
			end
			ST_FINISH: begin
				// on a miss, install the new block as most recent
				mreq.tag_we  = !found_q;
				mreq.rank_we = !found_q;
				mreq.wr_addr = tgt_idx;
				mreq.rank_wd = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= '0;
			rd_vld_s1 <= 1'b0;
			fill_q    <= '0;
			hits_q    <= '0;
			refs_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= walk_issue;
			if (accept || (state_q == ST_SEARCH && walk_done)) begin
				k_q <= '0;
			end else if (walk_issue) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (advance) begin
				out_vld_q <= 1'b1;
				refs_q    <= refs_q + TOT_W'(1);
				if (found_q) begin
					hits_q <= hits_q + TOT_W'(1);
				end
				if (!found_q && !full) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= k_q[IDX_W-1:0];
		if (accept) begin
			blk_q   <= req.block_number;
			found_q <= 1'b0;
		end
		if (state_q == ST_SEARCH && rd_vld_s1) begin
			if (tag_rd == blk_q && !found_q) begin
				found_q    <= 1'b1;
				slot_q     <= rd_idx_s1;
				hit_rank_q <= rank_rd;
			end
			if (rank_rd == IDX_W'(CACHE_ENTRIES - 1)) begin
				vic_q <= rd_idx_s1;
			end
		end
		if (advance) begin
			out_hit_q  <= found_q;
			out_evi_q  <= !found_q && full;
			out_hits_q <= found_q ? hits_q + TOT_W'(1) : hits_q;
			out_refs_q <= refs_q + TOT_W'(1);
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.hit             = out_hit_q;
	assign rsp.evicted         = out_evi_q;
	assign rsp.hit_count       = out_hits_q;
	assign rsp.reference_count = out_refs_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CACHE_ENTRIES))
		else $error("fill count beyond capacity");

	a_accept_search: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SEARCH)
		else $error("accepted beat did not start a search");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		advance && out_free |=> !(rsp.hit && rsp.evicted))
		else $error("hit reported with eviction");
endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb: LRU cache hit tracker testbench
// Drives block numbers through the request channel, predicts hit, eviction
// and running counts with a behavioural LRU model, and checks each response.
// ---------------------------------------------------------------------------
module tb;
	import lru_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;

	lru_req_if req();
	lru_rsp_if rsp();

	lru_cache_hit_tracker_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	typedef struct packed {
		logic        hit;
		logic        evicted;
		logic [31:0] hit_count;
		logic [31:0] reference_count;
	} lookup_result_t;

	// predictor state
	logic [TAG_W-1:0] model_tag[CACHE_ENTRIES];
	int               model_rank[CACHE_ENTRIES];
	int               model_fill;
	logic [31:0]      model_hits;
	logic [31:0]      model_refs;

	logic [31:0]    pending_blocks[$];
	lookup_result_t expected_results[$];
	int             mismatches;
	int             idle_tx;
	int             idle_rx;
	bit             quiet;
	bit             hold_tx;
	bit             done;
	bit             tx_beat;
	int             stall_cycles;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic lookup_result_t lookup_block(logic [31:0] blk);
		lookup_result_t r;
		int slot;
		int lim;
		bit found;
		slot = 0;
		found = 0;
		model_refs = model_refs + 32'd1;
		for (int k = 0; k < model_fill; k++) begin
			if (model_tag[k] == blk) begin
				slot = k;
				found = 1;
				break;
			end
		end
		r.evicted = 1'b0;
		if (found) begin
			model_hits = model_hits + 32'd1;
			lim = model_rank[slot];
		end else if (model_fill < CACHE_ENTRIES) begin
			lim = CACHE_ENTRIES;
			slot = model_fill;
			model_fill++;
		end else begin
			for (int k = 0; k < CACHE_ENTRIES; k++)
				if (model_rank[k] == CACHE_ENTRIES - 1) begin
					slot = k;
					break;
				end
			lim = CACHE_ENTRIES - 1;
			r.evicted = 1'b1;
		end
		for (int k = 0; k < model_fill; k++)
			if (model_rank[k] < lim) model_rank[k]++;
		model_tag[slot] = blk;
		model_rank[slot] = 0;
		r.hit = found;
		r.hit_count = model_hits;
		r.reference_count = model_refs;
		return r;
	endfunction

	// driver: advance on accepted beats, idle in bursts
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.block_number <= '0;
			idle_tx <= 0;
		end else begin
			if (idle_tx > 0) begin
				idle_tx <= idle_tx - 1;
				req.valid <= 1'b0;
			end else if (!quiet && tx_beat && $urandom_range(0, 5) == 0) begin
				idle_tx <= $urandom_range(0, 6);
				req.valid <= 1'b0;
			end else if (pending_blocks.size() > 0 && !hold_tx) begin
				req.valid <= 1'b1;
				req.block_number <= pending_blocks[0];
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			idle_rx <= 0;
		end else if (idle_rx > 0) begin
			idle_rx <= idle_rx - 1;
			rsp.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			idle_rx <= $urandom_range(0, 6);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// monitor: predict on request beats, check on response beats
	always @(posedge clk) begin
		lookup_result_t got;
		lookup_result_t want;
		if (arst_n) begin
			tx_beat <= req.valid && req.ready;
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (req.valid && req.ready) begin
				expected_results.push_back(lookup_block(req.block_number));
				void'(pending_blocks.pop_front());
			end
			if (rsp.valid && rsp.ready) begin
				got = {rsp.hit, rsp.evicted, rsp.hit_count, rsp.reference_count};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected beat: %h", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: want hit=%b ev=%b hc=%0d rc=%0d",
								" got hit=%b ev=%b hc=%0d rc=%0d"},
								want.hit, want.evicted, want.hit_count,
								want.reference_count, got.hit, got.evicted,
								got.hit_count, got.reference_count);
					end
				end
			end
			if (stall_cycles >= WATCHDOG_LIMIT && !done) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] pool[$];
		logic [31:0] b;
		int n;
		mismatches = 0;
		quiet = 0;
		hold_tx = 0;
		done = 0;
		tx_beat = 0;
		stall_cycles = 0;
		model_fill = 0;
		model_hits = '0;
		model_refs = '0;
		req.valid = 1'b0;
		req.block_number = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n = 1'b1;

		// directed: extremes, repeat hits, hit on most and least recent
		pending_blocks.push_back(32'h0000_0000);
		pending_blocks.push_back(32'h0000_0000);
		pending_blocks.push_back(32'hFFFF_FFFF);
		pending_blocks.push_back(32'h0000_0000);
		pending_blocks.push_back(32'hAAAA_AAAA);
		pending_blocks.push_back(32'h5555_5555);
		pending_blocks.push_back(32'hFFFF_FFFF);
		pending_blocks.push_back(32'h5555_5555);
		pending_blocks.push_back(32'h8000_0000);
		pending_blocks.push_back(32'h0000_0001);
		wait (pending_blocks.size() == 0 && expected_results.size() == 0);

		// hold off until the pipe drains
		hold_tx = 1;
		repeat (20) @(posedge clk);
		hold_tx = 0;

		// fill beyond capacity then cycle through: forces eviction of the oldest
		for (int i = 0; i < 260; i++) pending_blocks.push_back(32'h1000_0000 + i);
		for (int i = 0; i < 20; i++) pending_blocks.push_back(32'h1000_0000 + i);
		// random: a working set mixing reuse and fresh blocks
		for (int i = 0; i < 40; i++) pool.push_back($urandom);
		for (int i = 0; i < 110; i++) begin
			n = $urandom_range(0, 3);
			if (n == 0) b = $urandom;
			else if (n == 1) b = 32'h1000_0000 + $urandom_range(0, 259);
			else b = pool[$urandom_range(0, pool.size() - 1)];
			if (i == 80) begin
				wait (pending_blocks.size() == 0);
				quiet = 1;
			end
			pending_blocks.push_back(b);
		end
		wait (pending_blocks.size() == 0 && expected_results.size() == 0);
		done = 1;
		repeat (600) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ===== sim.f =====
src/lru_pkg.sv
src/lru_if.sv
src/lru_store.sv
src/lru_cache_hit_tracker_unit.sv
dv/tb.sv
